/* design/xesl_pkg.sv */
package xesl_pkg;

	// fifo geometry, depth must be a power of two
	localparam int FIFO_DEPTH = 64;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	localparam int BYTE_W  = 8;
	localparam int MARK_W  = 7;
	localparam int LEVEL_W = 7;
	localparam int CMP_W   = 16;

	typedef enum logic [1:0] {
		CMD_LINE_RX   = 2'd0,
		CMD_HOST_SEND = 2'd1,
		CMD_HOST_READ = 2'd2,
		CMD_TX_READY  = 2'd3
	} cmd_e_t;

	typedef enum logic [2:0] {
		REG_ESCAPE_CODE = 3'd0,
		REG_NAK_CODE    = 3'd1,
		REG_XON_CODE    = 3'd2,
		REG_XOFF_CODE   = 3'd3,
		REG_DATA_MIN    = 3'd4,
		REG_ESCAPE_MASK = 3'd5,
		REG_HIGH_MARK   = 3'd6,
		REG_LOW_MARK    = 3'd7
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE = 8'd27;
	localparam logic [BYTE_W-1:0] RST_NAK_CODE    = 8'd21;
	localparam logic [BYTE_W-1:0] RST_XON_CODE    = 8'd17;
	localparam logic [BYTE_W-1:0] RST_XOFF_CODE   = 8'd19;
	localparam logic [BYTE_W-1:0] RST_DATA_MIN    = 8'd32;
	localparam logic [BYTE_W-1:0] RST_ESCAPE_MASK = 8'd32;
	localparam logic [MARK_W-1:0] RST_HIGH_MARK   = 7'd48;
	localparam logic [MARK_W-1:0] RST_LOW_MARK    = 7'd16;

	// write side of a fifo store
	typedef struct packed {
		logic              en;
		logic [FIFO_AW-1:0] addr;
		logic [BYTE_W-1:0]  data;
	} ram_wr_t;

	typedef struct packed {
		logic               line_out_valid;
		logic [BYTE_W-1:0]  line_out_byte;
		logic               host_out_valid;
		logic [BYTE_W-1:0]  host_out_byte;
		logic               transmit_enabled;
		logic               remote_paused;
		logic               local_paused;
		logic               link_was_reset;
		logic [LEVEL_W-1:0] receive_level;
		logic [LEVEL_W-1:0] transmit_level;
	} result_t;

endpackage

/* design/xesl_item_if.sv */
interface xesl_item_if import xesl_pkg::*;;
	logic        valid;
	logic        ready;
	cmd_e_t      cmd;
	logic [7:0]  data_byte;

	modport source (output valid, cmd, data_byte, input ready);
	modport sink (input valid, cmd, data_byte, output ready);
endinterface

/* design/xesl_result_if.sv */
interface xesl_result_if import xesl_pkg::*;;
	logic               valid;
	logic               ready;
	logic               line_out_valid;
	logic [BYTE_W-1:0]  line_out_byte;
	logic               host_out_valid;
	logic [BYTE_W-1:0]  host_out_byte;
	logic               transmit_enabled;
	logic               remote_paused;
	logic               local_paused;
	logic               link_was_reset;
	logic [LEVEL_W-1:0] receive_level;
	logic [LEVEL_W-1:0] transmit_level;

	modport source (
		output valid, line_out_valid, line_out_byte, host_out_valid, host_out_byte,
		output transmit_enabled, remote_paused, local_paused, link_was_reset,
		output receive_level, transmit_level,
		input ready
	);
	modport sink (
		input valid, line_out_valid, line_out_byte, host_out_valid, host_out_byte,
		input transmit_enabled, remote_paused, local_paused, link_was_reset,
		input receive_level, transmit_level,
		output ready
	);
endinterface

/* design/xesl_cfg_if.sv */
interface xesl_cfg_if import xesl_pkg::*;;
	logic              valid;
	logic              ready;
	cfg_reg_t          index;
	logic [BYTE_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/xesl_fifo_ram.sv */
module xesl_fifo_ram import xesl_pkg::*; (
	input  logic               clk,
	input  ram_wr_t            wr,
	input  logic [FIFO_AW-1:0] raddr,
	output logic [BYTE_W-1:0]  rdata
);

	logic [BYTE_W-1:0] mem [FIFO_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		// bypass so the head byte is right when it is written this cycle
		if (wr.en && (wr.addr == raddr)) begin
			rdata <= wr.data;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/xon_xoff_escaped_serial_link.sv */
// channel  role  fields
// -------  ----  ---------------------------------------------------------
// item     sink  cmd, data_byte
// result   src   line_out_*, host_out_*, flags, receive/transmit_level
// cfg      sink  index, data (write only, always ready)
//
// one item per cycle sustained while results are taken; each item is held in the
// input register and its result is then registered in the result register
// fifo stores read ahead at the next head so the head byte is registered
// an item is taken while a result waits; stalls hold both registers
// arst_n restores the register reset values and an empty link, no clearing pass
module xon_xoff_escaped_serial_link import xesl_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	xesl_item_if.sink   item,
	xesl_result_if.source result,
	xesl_cfg_if.sink    cfg
);

	// configuration registers
	logic [BYTE_W-1:0] escape_code_q, nak_code_q, xon_code_q, xoff_code_q;
	logic [BYTE_W-1:0] data_min_q, escape_mask_q;
	logic [MARK_W-1:0] high_mark_q, low_mark_q;

	// input register
	logic              valid_s1;
	cmd_e_t            cmd_s1;
	logic [BYTE_W-1:0] byte_s1;

	// result register
	logic    res_valid_q;
	result_t res_q;
	result_t res_n;

	// link state
	logic [FIFO_AW-1:0] rx_head_q, rx_head_n, tx_head_q, tx_head_n;
	logic [FIFO_CW-1:0] rx_count_q, rx_count_n, tx_count_q, tx_count_n;
	logic partner_paused_q, partner_paused_n;
	logic esc_out_pending_q, esc_out_pending_n;
	logic [BYTE_W-1:0] held_byte_q, held_byte_n;
	logic xoff_pending_q, xoff_pending_n;
	logic xon_pending_q, xon_pending_n;
	logic self_paused_q, self_paused_n;
	logic escape_seen_q, escape_seen_n;
	logic sender_en_q, sender_en_n;

	logic              advance;
	logic              rx_full, tx_full;
	logic              rx_is_data;
	logic [BYTE_W-1:0] rx_data;
	logic              do_link_reset, queue_nak;
	ram_wr_t           rx_wr, tx_wr;
	logic [BYTE_W-1:0] rx_rdata, tx_rdata;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	assign rx_full = (rx_count_q == FIFO_CW'(FIFO_DEPTH));
	assign tx_full = (tx_count_q == FIFO_CW'(FIFO_DEPTH));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_code_q <= RST_ESCAPE_CODE;
			nak_code_q    <= RST_NAK_CODE;
			xon_code_q    <= RST_XON_CODE;
			xoff_code_q   <= RST_XOFF_CODE;
			data_min_q    <= RST_DATA_MIN;
			escape_mask_q <= RST_ESCAPE_MASK;
			high_mark_q   <= RST_HIGH_MARK;
			low_mark_q    <= RST_LOW_MARK;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ESCAPE_CODE: escape_code_q <= cfg.data;
				REG_NAK_CODE:    nak_code_q    <= cfg.data;
				REG_XON_CODE:    xon_code_q    <= cfg.data;
				REG_XOFF_CODE:   xoff_code_q   <= cfg.data;
				REG_DATA_MIN:    data_min_q    <= cfg.data;
				REG_ESCAPE_MASK: escape_mask_q <= cfg.data;
				REG_HIGH_MARK:   high_mark_q   <= cfg.data[MARK_W-1:0];
				REG_LOW_MARK:    low_mark_q    <= cfg.data[MARK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1  <= item.cmd;
			byte_s1 <= item.data_byte;
		end
	end

	// one decision step for the item in the input register
	always_comb begin
		rx_head_n         = rx_head_q;
		rx_count_n        = rx_count_q;
		tx_head_n         = tx_head_q;
		tx_count_n        = tx_count_q;
		partner_paused_n  = partner_paused_q;
		esc_out_pending_n = esc_out_pending_q;
		held_byte_n       = held_byte_q;
		xoff_pending_n    = xoff_pending_q;
		xon_pending_n     = xon_pending_q;
		self_paused_n     = self_paused_q;
		escape_seen_n     = escape_seen_q;
		sender_en_n       = sender_en_q;
		rx_wr             = '0;
		tx_wr             = '0;
		res_n             = '0;
		rx_is_data        = 1'b0;
		rx_data           = byte_s1;
		do_link_reset     = 1'b0;
		queue_nak         = 1'b0;

		if (advance) begin
			case (cmd_s1)
				CMD_LINE_RX: begin
					rx_is_data = 1'b1;
					if (escape_seen_q) begin
						// byte after an escape is data whatever it is
						rx_data       = byte_s1 ^ escape_mask_q;
						escape_seen_n = 1'b0;
					end else if (byte_s1 < data_min_q) begin
						// control codes, first match wins, unknown ones dropped
						rx_is_data = 1'b0;
						if (byte_s1 == xon_code_q) begin
							partner_paused_n = 1'b0;
							sender_en_n      = 1'b1;
						end else if (byte_s1 == xoff_code_q) begin
							partner_paused_n = 1'b1;
						end else if (byte_s1 == escape_code_q) begin
							escape_seen_n = 1'b1;
						end else if (byte_s1 == nak_code_q) begin
							do_link_reset = 1'b1;
						end
					end
					if (rx_is_data) begin
						if (!rx_full) begin
							rx_wr.en   = 1'b1;
							rx_wr.addr = rx_head_q + rx_count_q[FIFO_AW-1:0];
							rx_wr.data = rx_data;
							rx_count_n = rx_count_q + FIFO_CW'(1);
							if (!self_paused_q &&
							    (CMP_W'(rx_count_n) >= CMP_W'(high_mark_q))) begin
								self_paused_n  = 1'b1;
								xoff_pending_n = 1'b1;
								sender_en_n    = 1'b1;
							end
						end else begin
							// receive overflow: byte lost, link reset, nak queued
							do_link_reset = 1'b1;
							queue_nak     = 1'b1;
						end
					end
				end
				CMD_HOST_SEND: begin
					if (tx_full) begin
						do_link_reset = 1'b1;
						queue_nak     = 1'b1;
					end else begin
						tx_wr.en   = 1'b1;
						tx_wr.addr = tx_head_q + tx_count_q[FIFO_AW-1:0];
						tx_wr.data = byte_s1;
						tx_count_n = tx_count_q + FIFO_CW'(1);
						if (!partner_paused_q) begin
							sender_en_n = 1'b1;
						end
					end
				end
				CMD_HOST_READ: begin
					if (rx_count_q != '0) begin
						res_n.host_out_valid = 1'b1;
						res_n.host_out_byte  = rx_rdata;
						rx_head_n  = rx_head_q + FIFO_AW'(1);
						rx_count_n = rx_count_q - FIFO_CW'(1);
						if (self_paused_q &&
						    (CMP_W'(rx_count_n) <= CMP_W'(low_mark_q))) begin
							self_paused_n = 1'b0;
							xon_pending_n = 1'b1;
							sender_en_n   = 1'b1;
						end
					end
				end
				CMD_TX_READY: begin
					// priority: second half of an escape, xoff, xon, fifo data
					if (esc_out_pending_q) begin
						res_n.line_out_valid = 1'b1;
						res_n.line_out_byte  = held_byte_q ^ escape_mask_q;
						esc_out_pending_n    = 1'b0;
					end else if (xoff_pending_q) begin
						res_n.line_out_valid = 1'b1;
						res_n.line_out_byte  = xoff_code_q;
						xoff_pending_n       = 1'b0;
					end else if (xon_pending_q) begin
						res_n.line_out_valid = 1'b1;
						res_n.line_out_byte  = xon_code_q;
						xon_pending_n        = 1'b0;
					end else if ((tx_count_q != '0) && !partner_paused_q) begin
						res_n.line_out_valid = 1'b1;
						tx_head_n  = tx_head_q + FIFO_AW'(1);
						tx_count_n = tx_count_q - FIFO_CW'(1);
						if (tx_rdata < data_min_q) begin
							held_byte_n         = tx_rdata;
							esc_out_pending_n   = 1'b1;
							res_n.line_out_byte = escape_code_q;
						end else begin
							res_n.line_out_byte = tx_rdata;
						end
					end else begin
						sender_en_n = 1'b0;
					end
				end
				default: begin
				end
			endcase

			// link reset empties both fifos, sender enable untouched
			if (do_link_reset) begin
				rx_head_n            = '0;
				rx_count_n           = '0;
				tx_head_n            = '0;
				tx_count_n           = '0;
				partner_paused_n     = 1'b0;
				esc_out_pending_n    = 1'b0;
				held_byte_n          = '0;
				xoff_pending_n       = 1'b0;
				xon_pending_n        = 1'b1;
				self_paused_n        = 1'b0;
				escape_seen_n        = 1'b0;
				res_n.link_was_reset = 1'b1;
			end
			// nak goes first into the emptied transmit fifo, partner no longer paused
			if (queue_nak) begin
				tx_wr.en    = 1'b1;
				tx_wr.addr  = '0;
				tx_wr.data  = nak_code_q;
				tx_count_n  = FIFO_CW'(1);
				sender_en_n = 1'b1;
			end
		end

		res_n.transmit_enabled = sender_en_n;
		res_n.remote_paused    = partner_paused_n;
		res_n.local_paused     = self_paused_n;
		res_n.receive_level    = LEVEL_W'(rx_count_n);
		res_n.transmit_level   = LEVEL_W'(tx_count_n);
	end

	// link state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q         <= '0;
			rx_count_q        <= '0;
			tx_head_q         <= '0;
			tx_count_q        <= '0;
			partner_paused_q  <= 1'b0;
			esc_out_pending_q <= 1'b0;
			held_byte_q       <= '0;
			xoff_pending_q    <= 1'b0;
			xon_pending_q     <= 1'b1;
			self_paused_q     <= 1'b0;
			escape_seen_q     <= 1'b0;
			sender_en_q       <= 1'b0;
		end else begin
			rx_head_q         <= rx_head_n;
			rx_count_q        <= rx_count_n;
			tx_head_q         <= tx_head_n;
			tx_count_q        <= tx_count_n;
			partner_paused_q  <= partner_paused_n;
			esc_out_pending_q <= esc_out_pending_n;
			held_byte_q       <= held_byte_n;
			xoff_pending_q    <= xoff_pending_n;
			xon_pending_q     <= xon_pending_n;
			self_paused_q     <= self_paused_n;
			escape_seen_q     <= escape_seen_n;
			sender_en_q       <= sender_en_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	// fifo stores, read at the head that holds after this cycle
	xesl_fifo_ram u_rx_ram (
		.clk   (clk),
		.wr    (rx_wr),
		.raddr (rx_head_n),
		.rdata (rx_rdata)
	);

	xesl_fifo_ram u_tx_ram (
		.clk   (clk),
		.wr    (tx_wr),
		.raddr (tx_head_n),
		.rdata (tx_rdata)
	);

	assign result.valid            = res_valid_q;
	assign result.line_out_valid   = res_q.line_out_valid;
	assign result.line_out_byte    = res_q.line_out_byte;
	assign result.host_out_valid   = res_q.host_out_valid;
	assign result.host_out_byte    = res_q.host_out_byte;
	assign result.transmit_enabled = res_q.transmit_enabled;
	assign result.remote_paused    = res_q.remote_paused;
	assign result.local_paused     = res_q.local_paused;
	assign result.link_was_reset   = res_q.link_was_reset;
	assign result.receive_level    = res_q.receive_level;
	assign result.transmit_level   = res_q.transmit_level;

endmodule
